// ===== rtl/lru_byte_cache_defines.svh =====
// Assertion macros shared by the lru_byte_cache RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef LRU_BYTE_CACHE_DEFINES_SVH
`define LRU_BYTE_CACHE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define LBC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lru_byte_cache: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define LBC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru_byte_cache: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define LBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru_byte_cache: next-cycle implication violated");

`endif

// ===== rtl/lbc_pkg.sv =====
// Package for the LRU byte cache: field widths, opcodes, parameter defaults.
// No dependencies; used by lbc_cell and lru_byte_cache.
`default_nettype none

package lbc_pkg;

  // Fixed widths of the request and response fields
  localparam int OFFSET_WIDTH = 16;
  localparam int DATA_WIDTH   = 8;

  // Defaults for the top-level parameters
  localparam int DEF_ENTRIES     = 8;
  localparam int DEF_OFFSET_BITS = 16;

  // Request opcodes
  typedef enum logic [0:0] {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

// ===== rtl/lbc_cell.sv =====
// One slot of the recency-ordered cache chain: valid bit, tag and data byte.
// Loads its upstream neighbor's entry when told to shift. Uses lbc_pkg.
`default_nettype none

module lbc_cell #(
  parameter int OFFSET_BITS = lbc_pkg::DEF_OFFSET_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            shift,
  input  wire logic [OFFSET_BITS-1:0]          key,
  input  wire logic                            nb_valid,
  input  wire logic [OFFSET_BITS-1:0]          nb_tag,
  input  wire logic [lbc_pkg::DATA_WIDTH-1:0]  nb_data,
  output logic                                 valid,
  output logic [OFFSET_BITS-1:0]               tag,
  output logic [lbc_pkg::DATA_WIDTH-1:0]       data,
  output logic                                 hit
);

  // Valid bit: cleared by reset, follows the neighbor on a shift
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= nb_valid;
    end
  end

  // Payload needs no reset; only read behind the valid bit
  always_ff @(posedge clk) begin
    if (shift) begin
      tag  <= nb_tag;
      data <= nb_data;
    end
  end

  // Associative compare against the request tag
  assign hit = valid && (tag == key);

endmodule

`default_nettype wire

// ===== rtl/lru_byte_cache.sv =====
// Fully associative LRU byte cache, built as a recency-ordered chain of cells.
// Depends on lbc_pkg, lbc_cell and lru_byte_cache_defines.svh.
//
// Usage:
//   Requests enter on the s_ channel (tuser = opcode, tdata = offset, wdata);
//   responses leave on the m_ channel (tuser = miss, evicted;
//   tdata = out_offset, out_data). Every request gives exactly one response.
//   Cell 0 holds the most recent entry, and valid cells always form a prefix
//   of the chain. A hit moves its entry to cell 0 while the cells in front
//   of it step down by one; a write miss pushes the whole chain down, so the
//   entry falling out of the last cell is the one evicted.
//   The response is registered and is presented in the cycle after the request is accepted.
//   Throughput: one request per cycle while the receiver takes responses, set by
//   the compare and shift across all ENTRIES cells.
//   Reset empties the cache at once; no clearing pass is needed.
//   While the receiver stalls, the response register holds and s_tready
//   stays low until it is taken, so no request is lost.
`default_nettype none
`include "lru_byte_cache_defines.svh"

module lru_byte_cache #(
  parameter int ENTRIES     = lbc_pkg::DEF_ENTRIES,
  parameter int OFFSET_BITS = lbc_pkg::DEF_OFFSET_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [15:0] offset, [23:16] wdata
  input  wire logic [0:0]  s_tuser,   // [0] opcode
  // Response channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [15:0] out_offset, [23:16] out_data
  output logic [1:0]       m_tuser    // [0] miss, [1] evicted
);

  localparam int OW   = lbc_pkg::OFFSET_WIDTH;
  localparam int DW   = lbc_pkg::DATA_WIDTH;
  localparam int LAST = ENTRIES - 1;

  // Request fields
  logic [OW-1:0]          req_offset;
  logic [DW-1:0]          req_wdata;
  lbc_pkg::opcode_t       req_op;
  logic [OFFSET_BITS-1:0] key;
  logic [OW-1:0]          key16;
  logic [OW-1:0]          last_tag16;

  assign req_offset = s_tdata[OW-1:0];
  assign req_wdata  = s_tdata[OW+DW-1:OW];
  assign req_op     = lbc_pkg::opcode_t'(s_tuser[0]);

  // Chain signals
  logic [ENTRIES-1:0]     cell_valid;
  logic [ENTRIES-1:0]     cell_hit;
  logic [ENTRIES-1:0]     cell_shift;
  logic [OFFSET_BITS-1:0] cell_tag [ENTRIES];
  logic [DW-1:0]          cell_data [ENTRIES];

  logic          accept;
  logic          is_write;
  logic          any_hit;
  logic          full;
  logic [DW-1:0] hit_data;
  logic [DW-1:0] front_data;

  // Response register
  logic          miss;
  logic          evicted;
  logic [OW-1:0] out_offset;
  logic [DW-1:0] out_data;

  // Tag resize between the port width and the stored width
  generate
    if (OFFSET_BITS > OW) begin : g_wide
      assign key        = {{(OFFSET_BITS-OW){1'b0}}, req_offset};
      assign key16      = req_offset;
      assign last_tag16 = cell_tag[LAST][OW-1:0];
    end else if (OFFSET_BITS == OW) begin : g_same
      assign key        = req_offset;
      assign key16      = req_offset;
      assign last_tag16 = cell_tag[LAST];
    end else begin : g_narrow
      assign key        = req_offset[OFFSET_BITS-1:0];
      assign key16      = {{(OW-OFFSET_BITS){1'b0}}, key};
      assign last_tag16 = {{(OW-OFFSET_BITS){1'b0}}, cell_tag[LAST]};
    end
  endgenerate

  // Handshake
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_write = (req_op == lbc_pkg::OP_WRITE);
  assign any_hit  = |cell_hit;
  assign full     = cell_valid[LAST];

  // Data of the hitting cell (tags are unique among valid cells)
  always_comb begin
    hit_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_data = hit_data | (cell_data[i] & {DW{cell_hit[i]}});
    end
  end

  assign front_data = is_write ? req_wdata : hit_data;

  // Chain of cells; cell 0 takes the front entry
  generate
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic                   nb_valid;
      logic [OFFSET_BITS-1:0] nb_tag;
      logic [DW-1:0]          nb_data;

      // A cell shifts when the hit lies at or behind it, or on a write miss
      assign cell_shift[i] = accept && (any_hit ? (|(cell_hit >> i)) : is_write);

      if (i == 0) begin : g_head
        assign nb_valid = 1'b1;
        assign nb_tag   = key;
        assign nb_data  = front_data;
      end else begin : g_body
        assign nb_valid = cell_valid[i-1];
        assign nb_tag   = cell_tag[i-1];
        assign nb_data  = cell_data[i-1];
      end

      lbc_cell #(
        .OFFSET_BITS (OFFSET_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (cell_shift[i]),
        .key      (key),
        .nb_valid (nb_valid),
        .nb_tag   (nb_tag),
        .nb_data  (nb_data),
        .valid    (cell_valid[i]),
        .tag      (cell_tag[i]),
        .data     (cell_data[i]),
        .hit      (cell_hit[i])
      );
    end
  endgenerate

  // Response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      miss    <= !any_hit;
      evicted <= is_write && !any_hit && full;
      if (!is_write && any_hit) begin
        out_offset <= key16;
        out_data   <= hit_data;
      end else if (is_write && !any_hit && full) begin
        out_offset <= last_tag16;
        out_data   <= cell_data[LAST];
      end else begin
        out_offset <= '0;
        out_data   <= '0;
      end
    end
  end

  assign m_tdata = {out_data, out_offset};
  assign m_tuser = {evicted, miss};

  // Checks
  `LBC_ASSERT_ALWAYS(a_hit_unique, $onehot0(cell_hit))
  `LBC_ASSERT_ALWAYS(a_valid_prefix, ((cell_valid >> 1) & ~cell_valid) == '0)
  `LBC_ASSERT_IMPL(a_evict_is_miss, m_tvalid && evicted, miss)
  `LBC_ASSERT_NEXT(a_read_miss_resp, accept && !is_write && !any_hit, m_tvalid && miss && !evicted)
  `LBC_ASSERT_NEXT(a_write_front, accept && is_write, cell_valid[0] && cell_data[0] == $past(req_wdata))

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for lru_byte_cache: directed and random read/write requests, responses
// checked against an in-bench LRU predictor. Depends on lbc_pkg and lru_byte_cache.

module tb_top;

  localparam int CACHE_DEPTH = lbc_pkg::DEF_ENTRIES;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    lbc_pkg::opcode_t                 op;
    logic [lbc_pkg::OFFSET_WIDTH-1:0] offset;
    logic [lbc_pkg::DATA_WIDTH-1:0]   wdata;
  } cache_req_t;

  typedef struct packed {
    logic                             miss;
    logic                             evicted;
    logic [lbc_pkg::OFFSET_WIDTH-1:0] offset;
    logic [lbc_pkg::DATA_WIDTH-1:0]   data;
  } cache_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // [15:0] offset, [23:16] wdata
  logic [0:0]  s_tuser = lbc_pkg::OP_READ; // [0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [15:0] out_offset, [23:16] out_data
  logic [1:0]  m_tuser;         // [0] miss, [1] evicted

  // Predicted cache contents
  logic                             slot_valid [CACHE_DEPTH];
  logic [lbc_pkg::OFFSET_WIDTH-1:0] slot_tag   [CACHE_DEPTH];
  logic [lbc_pkg::DATA_WIDTH-1:0]   slot_byte  [CACHE_DEPTH];
  int                               slot_age   [CACHE_DEPTH];

  cache_resp_t expected_results [$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_cycles = 0;

  lru_byte_cache #(
    .ENTRIES     (lbc_pkg::DEF_ENTRIES),
    .OFFSET_BITS (lbc_pkg::DEF_OFFSET_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Slot s becomes most recent; valid slots younger than it (or all, on a fill) age by one
  function automatic void mark_most_recent(int s, logic was_valid);
    for (int j = 0; j < CACHE_DEPTH; j++) begin
      if (j != s && slot_valid[j] && (!was_valid || slot_age[j] < slot_age[s])) begin
        slot_age[j]++;
      end
    end
    slot_age[s] = 0;
  endfunction

  // Expected response for one accepted request; updates the predicted contents
  function automatic cache_resp_t predict_access(cache_req_t req);
    int          hit_idx;
    int          free_idx;
    int          lru_idx;
    int          oldest;
    cache_resp_t r;
    r = '{miss: 1'b1, evicted: 1'b0, offset: '0, data: '0};
    hit_idx = -1;
    free_idx = -1;
    lru_idx = -1;
    oldest = -1;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (slot_valid[i]) begin
        if (hit_idx < 0 && slot_tag[i] == req.offset) hit_idx = i;
        if (slot_age[i] > oldest) begin
          lru_idx = i;
          oldest = slot_age[i];
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (req.op == lbc_pkg::OP_READ) begin
      if (hit_idx >= 0) begin
        r.miss = 1'b0;
        r.offset = slot_tag[hit_idx];
        r.data = slot_byte[hit_idx];
        mark_most_recent(hit_idx, 1'b1);
      end
    end else if (hit_idx >= 0) begin
      r.miss = 1'b0;
      slot_byte[hit_idx] = req.wdata;
      mark_most_recent(hit_idx, 1'b1);
    end else if (free_idx >= 0) begin
      slot_valid[free_idx] = 1'b1;
      slot_tag[free_idx] = req.offset;
      slot_byte[free_idx] = req.wdata;
      mark_most_recent(free_idx, 1'b0);
    end else begin
      // full: the least recent entry goes out for write-back
      r.evicted = 1'b1;
      r.offset = slot_tag[lru_idx];
      r.data = slot_byte[lru_idx];
      slot_tag[lru_idx] = req.offset;
      slot_byte[lru_idx] = req.wdata;
      mark_most_recent(lru_idx, 1'b1);
    end
    return r;
  endfunction

  function automatic void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Response checker and receiver backpressure
  always @(posedge clk) begin : check_responses
    cache_resp_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual tuser=%b tdata=%h",
                 $time, m_tuser, m_tdata);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        compare_field("miss", 16'(exp_r.miss), 16'(m_tuser[0]));
        compare_field("evicted", 16'(exp_r.evicted), 16'(m_tuser[1]));
        compare_field("out_offset", exp_r.offset, m_tdata[15:0]);
        compare_field("out_data", 16'(exp_r.data), 16'(m_tdata[23:16]));
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: ends the run when no handshake happens for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // One request: optional idle gap, then hold valid until taken
  task automatic send_request(lbc_pkg::opcode_t op, logic [15:0] off, logic [7:0] wd);
    cache_req_t req;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    req = '{op: op, offset: off, wdata: wd};
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {wd, off};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_access(req));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Read misses on an empty cache
  task automatic test_empty_reads();
    send_request(lbc_pkg::OP_READ, 16'h0000, 8'h00);
    send_request(lbc_pkg::OP_READ, 16'hFFFF, 8'hFF);
  endtask

  // Write fill, read hit, write hit update, extreme offsets and bytes
  task automatic test_hit_update();
    send_request(lbc_pkg::OP_WRITE, 16'hFFFF, 8'hFF);
    send_request(lbc_pkg::OP_READ, 16'hFFFF, 8'h00);
    send_request(lbc_pkg::OP_WRITE, 16'hFFFF, 8'h00);
    send_request(lbc_pkg::OP_READ, 16'hFFFF, 8'hFF);
    send_request(lbc_pkg::OP_WRITE, 16'h0000, 8'hA5);
    send_request(lbc_pkg::OP_READ, 16'h0000, 8'h00);
  endtask

  // Fill every slot, reorder recency, then evict twice
  task automatic test_full_eviction();
    for (int k = 1; k < CACHE_DEPTH - 1; k++) begin
      send_request(lbc_pkg::OP_WRITE, 16'(k * 16'h1111), 8'(k * 8'h21));
    end
    send_request(lbc_pkg::OP_READ, 16'hFFFF, 8'h00);
    send_request(lbc_pkg::OP_WRITE, 16'h8000, 8'h5A);
    send_request(lbc_pkg::OP_READ, 16'h0000, 8'h00);
    send_request(lbc_pkg::OP_WRITE, 16'h0000, 8'hC3);
    send_request(lbc_pkg::OP_READ, 16'h8000, 8'h00);
  endtask

  // Random traffic, mostly on a small set of hot offsets so hits and evictions recur
  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
    logic [15:0]      hot_tags [16];
    int               pool_size;
    logic [15:0]      off;
    lbc_pkg::opcode_t op;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    pool_size = $urandom_range(9, 16);
    foreach (hot_tags[k]) hot_tags[k] = 16'($urandom);
    for (int i = 0; i < n_items; i++) begin
      // sender holds off until the cache has answered everything
      if (i % 150 == 149) wait_drained();
      if ($urandom_range(99) < 80) off = hot_tags[$urandom_range(pool_size - 1)];
      else off = 16'($urandom);
      op = lbc_pkg::opcode_t'(1'($urandom_range(1)));
      send_request(op, off, 8'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      slot_valid[i] = 1'b0;
      slot_tag[i] = '0;
      slot_byte[i] = '0;
      slot_age[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_reads();
    test_hit_update();
    test_full_eviction();
    test_random_traffic(18, 71, 360);
    test_random_traffic(71, 18, 360);
    test_random_traffic(0, 0, 360);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
